/* src/lsm_fe_pkg.sv */
// Shared types and constants for the least-squares frequency estimator.
`default_nettype none
package lsm_fe_pkg;

   localparam int WIDE_W    = 256;
   localparam int QUOT_W    = 64;
   localparam int SUM_W     = 64;
   localparam int COUNT_W   = 16;
   localparam int KHZ_W     = 24;
   localparam int PRESC_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 24;
   localparam int SCALE_W   = 61;
   localparam int DIV_CELLS = WIDE_W;

   // kHz to Hz, times 1e8
   localparam logic [36:0] SCALE_MULT = 37'd100000000000;

   localparam logic [KHZ_W-1:0]   CLOCK_KHZ_RESET = 24'd100000;
   localparam logic [PRESC_W-1:0] PRESCALE_RESET  = 16'd1;

   localparam logic [CSR_IDX_W-1:0] REG_CLOCK_KHZ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESCALE  = 1'b1;

   typedef struct packed {
      logic valid;
      logic zero_den;
   } tag_type;

endpackage
`default_nettype wire

/* src/lsm_fe_front.sv */
// Front pipeline: fit products, variance and covariance, scaled numerator.
`default_nettype none
module lsm_fe_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire logic [lsm_fe_pkg::COUNT_W-1:0]   sample_count,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]     sum_x,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]     sum_y,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]     sum_xy,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]     sum_xx,
   input  wire logic [lsm_fe_pkg::KHZ_W-1:0]     clock_khz,
   output lsm_fe_pkg::tag_type                   out_tag,
   output logic      [lsm_fe_pkg::WIDE_W-1:0]    out_num,
   output logic      [lsm_fe_pkg::WIDE_W-1:0]    out_den
);
   import lsm_fe_pkg::*;

   logic [SCALE_W-1:0] scale_ff;

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [47:0] nxx_lo_ff, nxx_hi_ff, nxy_lo_ff, nxy_hi_ff;
   logic [63:0] xx_ll_ff, xx_lh_ff, xx_hh_ff;
   logic [63:0] xy_ll_ff, xy_lh_ff, xy_hl_ff, xy_hh_ff;

   logic [79:0]  nsxx_ff, nsxy_ff;
   logic [127:0] sx2_ff, sxsy_ff;

   logic [WIDE_W-1:0] var_x_ff, cov3_ff;

   logic [63:0]       pp_lo_ff [8];
   logic [60:0]       pp_hi_ff [8];
   logic [WIDE_W-1:0] cov4_ff, cov5_ff, cov6_ff;
   logic              zero4_ff, zero5_ff, zero6_ff;

   logic [WIDE_W-1:0] half_lo_ff, half_hi_ff, num_ff;
   logic [WIDE_W-1:0] even_lo, odd_lo, even_hi, odd_hi;

   always_ff @(posedge clock) begin
      scale_ff <= SCALE_W'({37'd0, clock_khz} * {{(KHZ_W){1'b0}}, SCALE_MULT});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      even_lo = '0;
      odd_lo  = '0;
      even_hi = '0;
      odd_hi  = '0;
      for (int j = 0; j < 4; j++) begin
         even_lo[64*j +: 64] = pp_lo_ff[2*j];
         even_hi[64*j +: 64] = {3'd0, pp_hi_ff[2*j]};
      end
      for (int j = 0; j < 3; j++) begin
         odd_lo[32 + 64*j +: 64] = pp_lo_ff[2*j+1];
         odd_hi[32 + 64*j +: 64] = {3'd0, pp_hi_ff[2*j+1]};
      end
      odd_lo[255:224] = pp_lo_ff[7][31:0];
      odd_hi[255:224] = pp_hi_ff[7][31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxx_lo_ff <= {32'd0, sample_count} * {16'd0, sum_xx[31:0]};
         nxx_hi_ff <= {32'd0, sample_count} * {16'd0, sum_xx[63:32]};
         nxy_lo_ff <= {32'd0, sample_count} * {16'd0, sum_xy[31:0]};
         nxy_hi_ff <= {32'd0, sample_count} * {16'd0, sum_xy[63:32]};
         xx_ll_ff  <= {32'd0, sum_x[31:0]}  * {32'd0, sum_x[31:0]};
         xx_lh_ff  <= {32'd0, sum_x[31:0]}  * {32'd0, sum_x[63:32]};
         xx_hh_ff  <= {32'd0, sum_x[63:32]} * {32'd0, sum_x[63:32]};
         xy_ll_ff  <= {32'd0, sum_x[31:0]}  * {32'd0, sum_y[31:0]};
         xy_lh_ff  <= {32'd0, sum_x[31:0]}  * {32'd0, sum_y[63:32]};
         xy_hl_ff  <= {32'd0, sum_x[63:32]} * {32'd0, sum_y[31:0]};
         xy_hh_ff  <= {32'd0, sum_x[63:32]} * {32'd0, sum_y[63:32]};

         nsxx_ff <= {32'd0, nxx_lo_ff} + {nxx_hi_ff, 32'd0};
         nsxy_ff <= {32'd0, nxy_lo_ff} + {nxy_hi_ff, 32'd0};
         sx2_ff  <= {64'd0, xx_ll_ff} + {31'd0, xx_lh_ff, 33'd0} + {xx_hh_ff, 64'd0};
         sxsy_ff <= {64'd0, xy_ll_ff} + {32'd0, xy_lh_ff, 32'd0}
                  + {32'd0, xy_hl_ff, 32'd0} + {xy_hh_ff, 64'd0};

         var_x_ff <= {176'd0, nsxx_ff} - {128'd0, sx2_ff};
         cov3_ff  <= {176'd0, nsxy_ff} - {128'd0, sxsy_ff};

         for (int j = 0; j < 8; j++) begin
            pp_lo_ff[j] <= {32'd0, scale_ff[31:0]} * {32'd0, var_x_ff[32*j +: 32]};
            pp_hi_ff[j] <= {32'd0, scale_ff[60:32]} * {29'd0, var_x_ff[32*j +: 32]};
         end
         cov4_ff  <= cov3_ff;
         zero4_ff <= (cov3_ff == '0);

         half_lo_ff <= even_lo + odd_lo;
         half_hi_ff <= even_hi + odd_hi;
         cov5_ff    <= cov4_ff;
         zero5_ff   <= zero4_ff;

         num_ff   <= half_lo_ff + {half_hi_ff[223:0], 32'd0};
         cov6_ff  <= cov5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   assign out_tag.valid    = v6_ff;
   assign out_tag.zero_den = zero6_ff;
   assign out_num          = num_ff;
   assign out_den          = cov6_ff;

endmodule
`default_nettype wire

/* src/lsm_fe_div_cell.sv */
// One restoring-division cell: one quotient bit per item per cycle while en is high.
`default_nettype none
module lsm_fe_div_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  lsm_fe_pkg::tag_type                  in_tag,
   input  wire logic [lsm_fe_pkg::WIDE_W-1:0]   in_rem,
   input  wire logic [lsm_fe_pkg::WIDE_W-1:0]   in_num,
   input  wire logic [lsm_fe_pkg::WIDE_W-1:0]   in_den,
   input  wire logic [lsm_fe_pkg::QUOT_W-1:0]   in_quot,
   output lsm_fe_pkg::tag_type                  out_tag,
   output logic      [lsm_fe_pkg::WIDE_W-1:0]   out_rem,
   output logic      [lsm_fe_pkg::WIDE_W-1:0]   out_num,
   output logic      [lsm_fe_pkg::WIDE_W-1:0]   out_den,
   output logic      [lsm_fe_pkg::QUOT_W-1:0]   out_quot
);
   import lsm_fe_pkg::*;

   tag_type           tag_ff;
   logic [WIDE_W-1:0] rem_ff, num_ff, den_ff;
   logic [QUOT_W-1:0] quot_ff;

   logic [WIDE_W:0]   shifted;
   logic              take;
   logic [WIDE_W:0]   diff;

   always_comb begin
      shifted = {in_rem, in_num[WIDE_W-1]};
      take    = (shifted >= {1'b0, in_den});
      diff    = shifted - {1'b0, in_den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= take ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
         num_ff  <= {in_num[WIDE_W-2:0], 1'b0};
         den_ff  <= in_den;
         quot_ff <= {in_quot[QUOT_W-2:0], take};
      end
   end

   assign out_tag  = tag_ff;
   assign out_rem  = rem_ff;
   assign out_num  = num_ff;
   assign out_den  = den_ff;
   assign out_quot = quot_ff;

endmodule
`default_nettype wire

/* src/lsm_fe_back.sv */
// Prescaler multiply with saturation and zero-denominator masking.
`default_nettype none
module lsm_fe_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  lsm_fe_pkg::tag_type                  in_tag,
   input  wire logic [lsm_fe_pkg::QUOT_W-1:0]   in_quot,
   input  wire logic [lsm_fe_pkg::PRESC_W-1:0]  prescale,
   output lsm_fe_pkg::tag_type                  out_tag,
   output logic      [lsm_fe_pkg::QUOT_W-1:0]   out_freq,
   output logic                                 out_valid_res
);
   import lsm_fe_pkg::*;

   tag_type     tag_ff;
   logic [47:0] pa_ff, pb_ff;
   logic [15:0] div_eff;
   logic [79:0] sum;

   assign div_eff = (prescale == '0) ? 16'd1 : prescale;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= {16'd0, in_quot[31:0]}  * {32'd0, div_eff};
         pb_ff <= {16'd0, in_quot[63:32]} * {32'd0, div_eff};
      end
   end

   always_comb begin
      sum = {pb_ff, 32'd0} + {32'd0, pa_ff};
      if (tag_ff.zero_den) begin
         out_freq = '0;
      end else if (sum[79:64] != '0) begin
         out_freq = '1;
      end else begin
         out_freq = sum[63:0];
      end
      out_valid_res = !tag_ff.zero_den;
   end

   assign out_tag = tag_ff;

endmodule
`default_nettype wire

/* src/lsm_frequency_estimator_core.sv */
// Top level of the least-squares frequency estimator.
//
// A beat on the req_ channel carries one set of fit sums; one beat on the
// rsp_ channel returns frequency_e8 (Hz times 1e8) and valid_res for it.
// A new req_ beat is taken every cycle while req_stall is low. On its way
// to the rsp_ beat an accepted req_ beat passes six front stages (products,
// differences, scaled numerator), a row of 256 division cells each settling
// one quotient bit, one prescaler multiply stage, and the output register.
// The output register has a skid entry behind it; while rsp_stall holds and
// both are full, req_stall rises and the whole pipeline holds its beats.
// csr_ writes set clock_khz (index 0) and prescale_division (index 1);
// write them only while no beat is in flight. A zero denominator returns
// frequency_e8 of zero with valid_res low.
// Synchronous reset empties the pipeline and output stages and restores
// clock_khz to 100000 kHz and prescale_division to 1.
`default_nettype none
module lsm_frequency_estimator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [lsm_fe_pkg::COUNT_W-1:0]    req_sample_count,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]      req_sum_x,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]      req_sum_y,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]      req_sum_xy,
   input  wire logic [lsm_fe_pkg::SUM_W-1:0]      req_sum_xx,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [lsm_fe_pkg::QUOT_W-1:0]     rsp_frequency_e8,
   output logic                                   rsp_valid_res,
   input  wire logic                              csr_write,
   input  wire logic [lsm_fe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsm_fe_pkg::CSR_DAT_W-1:0]  csr_data
);
   import lsm_fe_pkg::*;

   logic [KHZ_W-1:0]   clock_khz_ff;
   logic [PRESC_W-1:0] prescale_ff;

   logic adv;

   tag_type           chain_tag  [DIV_CELLS+1];
   logic [WIDE_W-1:0] chain_rem  [DIV_CELLS+1];
   logic [WIDE_W-1:0] chain_num  [DIV_CELLS+1];
   logic [WIDE_W-1:0] chain_den  [DIV_CELLS+1];
   logic [QUOT_W-1:0] chain_quot [DIV_CELLS+1];

   tag_type           back_tag;
   logic [QUOT_W-1:0] back_freq;
   logic              back_valid_res;
   logic              arrive;

   logic              out_v_ff, skid_v_ff;
   logic [QUOT_W-1:0] out_freq_ff, skid_freq_ff;
   logic              out_res_ff, skid_res_ff;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_khz_ff <= CLOCK_KHZ_RESET;
         prescale_ff  <= PRESCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CLOCK_KHZ: clock_khz_ff <= csr_data;
            REG_PRESCALE:  prescale_ff  <= csr_data[PRESC_W-1:0];
            default:       ;
         endcase
      end
   end

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   lsm_fe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (req_valid),
      .sample_count (req_sample_count),
      .sum_x        (req_sum_x),
      .sum_y        (req_sum_y),
      .sum_xy       (req_sum_xy),
      .sum_xx       (req_sum_xx),
      .clock_khz    (clock_khz_ff),
      .out_tag      (chain_tag[0]),
      .out_num      (chain_num[0]),
      .out_den      (chain_den[0])
   );

   assign chain_rem[0]  = '0;
   assign chain_quot[0] = '0;

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
      lsm_fe_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_tag   (chain_tag[k]),
         .in_rem   (chain_rem[k]),
         .in_num   (chain_num[k]),
         .in_den   (chain_den[k]),
         .in_quot  (chain_quot[k]),
         .out_tag  (chain_tag[k+1]),
         .out_rem  (chain_rem[k+1]),
         .out_num  (chain_num[k+1]),
         .out_den  (chain_den[k+1]),
         .out_quot (chain_quot[k+1])
      );
   end

   lsm_fe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .in_tag        (chain_tag[DIV_CELLS]),
      .in_quot       (chain_quot[DIV_CELLS]),
      .prescale      (prescale_ff),
      .out_tag       (back_tag),
      .out_freq      (back_freq),
      .out_valid_res (back_valid_res)
   );

   assign arrive = adv && back_tag.valid;
   assign pop    = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end
         out_v_ff <= 1'b1;
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_freq_ff <= skid_freq_ff;
            out_res_ff  <= skid_res_ff;
         end
      end else if (arrive) begin
         if (out_v_ff && !pop) begin
            skid_freq_ff <= back_freq;
            skid_res_ff  <= back_valid_res;
         end else begin
            out_freq_ff <= back_freq;
            out_res_ff  <= back_valid_res;
         end
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_frequency_e8 = out_freq_ff;
   assign rsp_valid_res    = out_res_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without output entry");

   a_skid_fills : assert property (@(posedge clock) disable iff (reset)
      (arrive && out_v_ff && rsp_stall) |=> skid_v_ff)
      else $error("beat arriving at stalled output not held in skid");

   a_zero_den_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_frequency_e8 == '0))
      else $error("invalid result carries nonzero frequency");

endmodule
`default_nettype wire

/* sim/lsm_fe_checker.sv */
// Watches the estimator channels, predicts each frequency result and compares it.
module lsm_fe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_sample_count,
   input  logic [63:0] req_sum_x,
   input  logic [63:0] req_sum_y,
   input  logic [63:0] req_sum_xy,
   input  logic [63:0] req_sum_xx,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_frequency_e8,
   input  logic        rsp_valid_res,
   input  logic        csr_write,
   input  logic [lsm_fe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsm_fe_pkg::CSR_DAT_W-1:0] csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output int          invalid_seen
);
   import lsm_fe_pkg::*;

   typedef struct {
      logic [63:0] freq;
      logic        ok;
   } freq_result_type;

   freq_result_type pending_freqs[$];
   logic [KHZ_W-1:0]   khz_now;
   logic [PRESC_W-1:0] presc_now;

   function automatic freq_result_type estimate_freq(input logic [15:0] n, input logic [63:0] sx,
         input logic [63:0] sy, input logic [63:0] sxy, input logic [63:0] sxx);
      logic [255:0] var_x, cov, num, scale;
      logic [63:0]  q;
      logic [79:0]  prod;
      logic [15:0]  div;
      freq_result_type r;
      var_x = 256'(n) * 256'(sxx) - 256'(sx) * 256'(sx);
      cov   = 256'(n) * 256'(sxy) - 256'(sx) * 256'(sy);
      if (cov == 256'd0) begin
         r.freq = 64'd0;
         r.ok   = 1'b0;
         return r;
      end
      scale = 256'(khz_now) * 256'(1000) * 256'(100000000);
      num   = scale * var_x;
      q     = 64'(num / cov);
      div   = (presc_now == 16'd0) ? 16'd1 : presc_now;
      prod  = 80'(q) * 80'(div);
      r.freq = (prod[79:64] != 16'd0) ? 64'hffff_ffff_ffff_ffff : prod[63:0];
      r.ok   = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin
      freq_result_type want;
      if (reset) begin
         pending_freqs.delete();
         khz_now   <= CLOCK_KHZ_RESET;
         presc_now <= PRESCALE_RESET;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_CLOCK_KHZ) khz_now <= csr_data[KHZ_W-1:0];
            else if (csr_index == REG_PRESCALE) presc_now <= csr_data[PRESC_W-1:0];
         end
         if (req_valid && !req_stall)
            pending_freqs.push_back(estimate_freq(req_sample_count, req_sum_x, req_sum_y,
                                                  req_sum_xy, req_sum_xx));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (!rsp_valid_res) invalid_seen++;
            if (pending_freqs.size() == 0) begin
               report_mismatch("unexpected beat", rsp_frequency_e8, 64'd0);
            end else begin
               want = pending_freqs.pop_front();
               if (rsp_frequency_e8 !== want.freq)
                  report_mismatch("frequency_e8", rsp_frequency_e8, want.freq);
               if (rsp_valid_res !== want.ok)
                  report_mismatch("valid_res", 64'(rsp_valid_res), 64'(want.ok));
            end
         end
      end
      outstanding = pending_freqs.size();
   end

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
      invalid_seen = 0;
   end
endmodule

/* sim/tb_lsm_frequency_estimator_core.sv */
// Stimulus, configuration phases and verdict for the frequency estimator core.
module tb_lsm_frequency_estimator_core;
   import lsm_fe_pkg::*;

   localparam int DRAIN_CYCLES = 300;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_sample_count = '0;
   logic [63:0] req_sum_x = '0, req_sum_y = '0, req_sum_xy = '0, req_sum_xx = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_frequency_e8;
   logic        rsp_valid_res;
   logic        csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int  mismatches, outstanding, results_seen, invalid_seen;
   int  hold_count = 0;
   bit  hold_long = 1'b0;
   int  idle_count = 0;
   int  sent_count = 0;
   bit  quiet = 1'b0;

   always #10 clock = ~clock;

   lsm_frequency_estimator_core uut (.*);

   lsm_fe_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_long && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 31);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_beat(input logic [15:0] n, input logic [63:0] sx, input logic [63:0] sy,
         input logic [63:0] sxy, input logic [63:0] sxx);
      req_valid        <= 1'b1;
      req_sample_count <= n;
      req_sum_x        <= sx;
      req_sum_y        <= sy;
      req_sum_xy       <= sxy;
      req_sum_xx       <= sxx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      while (!quiet && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Build sums from a line with noise, then maybe corrupt one of them.
   task automatic send_fit();
      logic [15:0] n;
      logic [63:0] x, y, dx, dy, sx, sy, sxy, sxx;
      n  = ($urandom_range(0, 99) < 3) ? 16'($urandom_range(1000, 65535))
                                       : 16'($urandom_range(2, 40));
      x  = 64'($urandom);
      dx = 64'($urandom_range(1, 100000));
      y  = rand64() >> $urandom_range(0, 63);
      dy = 64'($urandom_range(0, 1000000));
      sx = 0; sy = 0; sxy = 0; sxx = 0;
      for (int i = 0; i < n; i++) begin
         logic [63:0] yi;
         yi  = y + 64'(i) * dy + 64'($urandom_range(0, 50));
         sx  += x;
         sy  += yi;
         sxy += x * yi;
         sxx += x * x;
         x   += dx;
      end
      if ($urandom_range(0, 99) < 8) begin
         case ($urandom_range(0, 3))
            0: sx = rand64();
            1: sy = rand64();
            2: sxy = rand64();
            default: sxx = rand64();
         endcase
      end
      send_beat(n, sx, sy, sxy, sxx);
   endtask

   task automatic send_directed();
      logic [63:0] a, b;
      a = rand64();
      b = rand64();
      send_beat(16'd0, 64'd0, 64'd0, 64'd0, 64'd0);
      send_beat(16'hffff, '1, '1, '1, '1);
      send_beat(16'd1, a, b, a * b, a * a);
      send_beat(16'd0, a, b, rand64(), rand64());
      send_beat(16'd1, 64'd0, b, 64'd1, '1);
      send_beat(16'd2, 64'd3, 64'd5, 64'd7, 64'd4);
      send_beat(16'd10, 64'd45, 64'd90, 64'd570, 64'd285);
      send_beat(16'd10, 64'd45, 64'd9000, 64'd57000, 64'd285);
      send_beat(16'hffff, 64'd1, 64'd1, 64'd1, 64'd1);
      send_beat(16'd3, '1, 64'd0, 64'd0, '1);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   logic [23:0] khz_set[6]   = '{24'd100000, 24'd1, 24'hffffff, 24'd0, 24'd0, 24'd250000};
   logic [15:0] presc_set[6] = '{16'd1, 16'd0, 16'hffff, 16'd1, 16'd0, 16'd7};

   initial begin
      khz_set[4]   = 24'($urandom);
      presc_set[4] = 16'($urandom);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            write_csr(REG_CLOCK_KHZ, khz_set[p]);
            write_csr(REG_PRESCALE, 24'(presc_set[p]));
         end
         quiet = (p == 4);
         send_directed();
         for (int k = 0; k < 205; k++) begin
            if (p == 2 && k == 20) hold_long = 1'b1;
            if (p == 1 && k == 100) drain();
            if ($urandom_range(0, 99) < 75) send_fit();
            else send_beat(16'($urandom), rand64(), rand64(), rand64(), rand64());
         end
         drain();
      end
      $display("sent %0d beats over 6 register settings; %0d results, %0d with zero denominator",
               sent_count, results_seen, invalid_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

/* files.f */
src/lsm_fe_pkg.sv
src/lsm_fe_front.sv
src/lsm_fe_div_cell.sv
src/lsm_fe_back.sv
src/lsm_frequency_estimator_core.sv
sim/lsm_fe_checker.sv
sim/tb_lsm_frequency_estimator_core.sv
